FILE: sv/rcrf_pkg.sv
// shared types and constants for the remote control register file
`timescale 1ns / 1ps

package rcrf_pkg;

   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 12;
   localparam int SIZE_W  = 4;
   localparam int WIDX_W  = ADDR_W - 2;
   localparam int CH_W    = 4;
   localparam int BIT_W   = 5;

   // interrupt register addresses
   localparam logic [ADDR_W-1:0] ADDR_RAW    = 12'h0A0;
   localparam logic [ADDR_W-1:0] ADDR_STATUS = 12'h0A4;
   localparam logic [ADDR_W-1:0] ADDR_ENABLE = 12'h0A8;
   localparam logic [ADDR_W-1:0] ADDR_CLEAR  = 12'h0AC;

   // channel layout
   localparam int CONF0_BASE      = 'h20;
   localparam int CH_STRIDE       = 'h8;
   localparam int CONF1_OFFSET    = 'h4;
   localparam int CONF0_RESET_BIT = 24;
   localparam int TX_DONE_SPACING = 3;

   localparam logic [SIZE_W-1:0] WORD_BYTES = 4'd4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_RD_RAW,
      OP_RD_STATUS,
      OP_RD_ENABLE,
      OP_RD_STORE,
      OP_WR_ENABLE,
      OP_WR_CLEAR,
      OP_WR_STORE,
      OP_WR_TXDONE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [WIDX_W-1:0]   widx;
      logic [DATA_W-1:0]   data;
      logic [BIT_W-1:0]    raw_bit;
   } entry_type;

endpackage

FILE: sv/rcrf_front.sv
// front end: checks and classifies each bus word into a queue entry
`timescale 1ns / 1ps

module rcrf_front #(
   parameter int WINDOW_BYTES  = 4096,
   parameter int CHANNEL_COUNT = 8
) (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [rcrf_pkg::ADDR_W-1:0]   req_address,
   input  logic [rcrf_pkg::DATA_W-1:0]   req_write_data,
   input  logic [rcrf_pkg::SIZE_W-1:0]   req_access_size,
   input  logic                          clearing,
   input  logic                          q_full,
   output logic                          push,
   output rcrf_pkg::entry_type           push_entry
);
   import rcrf_pkg::*;

   localparam int CONF1_FIRST = CONF0_BASE + CONF1_OFFSET;
   localparam int CONF1_LIMIT = CONF0_BASE + CH_STRIDE * CHANNEL_COUNT;

   logic              in_window;
   logic              word_ok;
   logic              is_conf1;
   logic [ADDR_W-1:0] ch_offset;
   logic [CH_W-1:0]   channel;

   // handshake: hold off during the store clearing pass or when the queue is full
   assign req_ready = !clearing && !q_full;
   assign push      = req_valid && req_ready;

   // access checks
   assign in_window = 32'(req_address) < WINDOW_BYTES;
   assign word_ok   = (req_access_size == WORD_BYTES) && (req_address[1:0] == 2'b00)
                      && in_window;

   // conf1 word of some channel
   assign is_conf1  = (32'(req_address) >= CONF1_FIRST) && (32'(req_address) < CONF1_LIMIT)
                      && (req_address[2:0] == 3'b100);
   assign ch_offset = req_address - ADDR_W'(CONF1_FIRST);
   assign channel   = CH_W'(ch_offset >> 3);

   // classify the word
   always_comb begin
      push_entry.widx    = req_address[ADDR_W-1:2];
      push_entry.data    = req_write_data;
      push_entry.raw_bit = BIT_W'(channel * TX_DONE_SPACING);
      push_entry.op      = OP_NONE;
      if (word_ok) begin
         if (!req_mode) begin
            if (req_address == ADDR_RAW) begin
               push_entry.op = OP_RD_RAW;
            end else if (req_address == ADDR_STATUS) begin
               push_entry.op = OP_RD_STATUS;
            end else if (req_address == ADDR_ENABLE) begin
               push_entry.op = OP_RD_ENABLE;
            end else if (req_address == ADDR_CLEAR) begin
               push_entry.op = OP_NONE;
            end else begin
               push_entry.op = OP_RD_STORE;
            end
         end else begin
            if (req_address == ADDR_ENABLE) begin
               push_entry.op = OP_WR_ENABLE;
            end else if (req_address == ADDR_CLEAR) begin
               push_entry.op = OP_WR_CLEAR;
            end else if (is_conf1 && req_write_data[0]) begin
               push_entry.op   = OP_WR_TXDONE;
               push_entry.data = req_write_data & ~DATA_W'(1);
            end else begin
               push_entry.op = OP_WR_STORE;
            end
         end
      end
   end

endmodule

FILE: sv/rcrf_queue.sv
// two-entry queue between the front end and the back end
`timescale 1ns / 1ps

module rcrf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rcrf_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output rcrf_pkg::entry_type  head
);
   import rcrf_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   entry_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W:0]       count_ff;
   logic [PTR_W:0]       count_in;

   assign full  = count_ff == (PTR_W+1)'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: sv/rcrf_back.sv
// back end: word store, interrupt registers and result register
`timescale 1ns / 1ps

module rcrf_back #(
   parameter int WINDOW_BYTES  = 4096,
   parameter int CHANNEL_COUNT = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  rcrf_pkg::entry_type           head,
   output logic                          pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rcrf_pkg::DATA_W-1:0]   rsp_read_data,
   output logic                          rsp_irq_level
);
   import rcrf_pkg::*;

   localparam int STORE_WORDS     = WINDOW_BYTES / 4;
   localparam int IDX_W           = $clog2(STORE_WORDS);
   localparam int CONF0_FIRST_IDX = CONF0_BASE / 4;
   localparam int CONF0_LAST_IDX  = (CONF0_BASE + CH_STRIDE * (CHANNEL_COUNT - 1)) / 4;

   logic [DATA_W-1:0] mem [STORE_WORDS];
   logic [DATA_W-1:0] mem_rd_ff;

   logic              clearing_ff;
   logic [IDX_W-1:0]  clr_idx_ff;
   logic              clr_conf0;

   logic [DATA_W-1:0] raw_ff;
   logic [DATA_W-1:0] raw_in;
   logic [DATA_W-1:0] enable_ff;
   logic [DATA_W-1:0] enable_in;

   logic              p_valid_ff;
   logic              p_use_mem_ff;
   logic [DATA_W-1:0] p_value_ff;
   logic              p_irq_ff;
   logic              p_ready;
   logic [DATA_W-1:0] rd_value;

   logic              out_valid_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_irq_ff;

   logic [IDX_W-1:0]  word_idx;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [DATA_W-1:0] mem_wd;

   assign clearing      = clearing_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;
   assign rsp_irq_level = out_irq_ff;

   // issue control
   assign p_ready  = !out_valid_ff || rsp_ready;
   assign pop      = !q_empty && !clearing_ff && (!p_valid_ff || p_ready);
   assign word_idx = IDX_W'(head.widx);

   // interrupt register updates
   always_comb begin
      raw_in    = raw_ff;
      enable_in = enable_ff;
      if (pop) begin
         case (head.op)
            OP_WR_ENABLE: enable_in = head.data;
            OP_WR_CLEAR:  raw_in    = raw_ff & ~head.data;
            OP_WR_TXDONE: raw_in    = raw_ff | (DATA_W'(1) << head.raw_bit);
            default:      raw_in    = raw_ff;
         endcase
      end
   end

   // read value of the interrupt registers
   always_comb begin
      case (head.op)
         OP_RD_RAW:    rd_value = raw_ff;
         OP_RD_STATUS: rd_value = raw_ff & enable_ff;
         OP_RD_ENABLE: rd_value = enable_ff;
         default:      rd_value = '0;
      endcase
   end

   // store write port, shared with the clearing pass
   assign clr_conf0 = (32'(clr_idx_ff) >= CONF0_FIRST_IDX) && (32'(clr_idx_ff) <= CONF0_LAST_IDX)
                      && !clr_idx_ff[0];
   assign mem_we    = clearing_ff
                      || (pop && ((head.op == OP_WR_STORE) || (head.op == OP_WR_TXDONE)));
   assign mem_wa    = clearing_ff ? clr_idx_ff : word_idx;
   assign mem_wd    = clearing_ff ? (clr_conf0 ? (DATA_W'(1) << CONF0_RESET_BIT) : '0)
                                  : head.data;

   // word store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (pop && (head.op == OP_RD_STORE)) begin
         mem_rd_ff <= mem[word_idx];
      end
   end

   // clearing pass and interrupt registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
         raw_ff      <= '0;
         enable_ff   <= '0;
      end else begin
         raw_ff    <= raw_in;
         enable_ff <= enable_in;
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_W'(STORE_WORDS - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
      end
   end

   // issued stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (pop) begin
         p_valid_ff <= 1'b1;
      end else if (p_ready) begin
         p_valid_ff <= 1'b0;
      end
   end

   // issued stage payload
   always_ff @(posedge clock) begin
      if (pop) begin
         p_use_mem_ff <= head.op == OP_RD_STORE;
         p_value_ff   <= rd_value;
         p_irq_ff     <= |(raw_in & enable_in);
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (p_valid_ff && p_ready) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (p_valid_ff && p_ready) begin
         out_data_ff <= p_use_mem_ff ? mem_rd_ff : p_value_ff;
         out_irq_ff  <= p_irq_ff;
      end
   end

endmodule

FILE: sv/remote_ctrl_register_file_irq.sv
// top level of the remote control register file with interrupt line
`timescale 1ns / 1ps

// Register file of a remote control peripheral with one interrupt output.
// The req_ channel takes one bus word per handshake: mode (0 read, 1 write),
// byte address, write data and access size. Only aligned 4-byte accesses
// inside the window take effect; all others return 0 and change nothing.
// The rsp_ channel returns one word per request: the read data (0 for
// writes) and the interrupt level after the access (raw AND enable).
// Each request goes through the queue, issued stage and result register.
// Throughput: one access per cycle while rsp_ready stays high, set by the
// single port of the word store. A two-entry queue sits between the
// request decoder and the store, and a result register holds the response,
// so requests keep flowing until the queue fills when rsp_ready is low.
// Reset: after reset the store is cleared one word per cycle, all
// WINDOW_BYTES/4 words (1024 by default); each channel's conf0 word is
// loaded with bit 24 set. req_ready stays low during that pass.
module remote_ctrl_register_file_irq #(
   parameter int WINDOW_BYTES  = 4096,
   parameter int CHANNEL_COUNT = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [rcrf_pkg::ADDR_W-1:0]   req_address,
   input  logic [rcrf_pkg::DATA_W-1:0]   req_write_data,
   input  logic [rcrf_pkg::SIZE_W-1:0]   req_access_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rcrf_pkg::DATA_W-1:0]   rsp_read_data,
   output logic                          rsp_irq_level
);
   import rcrf_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      q_full;
   logic      q_empty;
   entry_type head;
   logic      clearing;

   // request decode
   rcrf_front #(
      .WINDOW_BYTES  (WINDOW_BYTES),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_access_size (req_access_size),
      .clearing        (clearing),
      .q_full          (q_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   // decoupling queue
   rcrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (head)
   );

   // store and interrupt logic
   rcrf_back #(
      .WINDOW_BYTES  (WINDOW_BYTES),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .head          (head),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data),
      .rsp_irq_level (rsp_irq_level)
   );

endmodule

FILE: test/rcrf_checker.sv
// checker for the register file: predicts every response word and compares it
`timescale 1ns / 1ps

module rcrf_checker #(
   parameter int WINDOW_BYTES  = 4096,
   parameter int CHANNEL_COUNT = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_mode,
   input  logic [rcrf_pkg::ADDR_W-1:0]   req_address,
   input  logic [rcrf_pkg::DATA_W-1:0]   req_write_data,
   input  logic [rcrf_pkg::SIZE_W-1:0]   req_access_size,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [rcrf_pkg::DATA_W-1:0]   rsp_read_data,
   input  logic                          rsp_irq_level,
   output int                            mismatch_count,
   output int                            pending_words,
   output int                            words_checked,
   output int                            txdone_events
);
   import rcrf_pkg::*;

   localparam int STORE_WORDS = WINDOW_BYTES / 4;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_level;
   } bus_reply_type;

   // shadow copy of the block state
   logic [DATA_W-1:0] shadow_store [STORE_WORDS];
   logic [DATA_W-1:0] shadow_raw;
   logic [DATA_W-1:0] shadow_enable;

   bus_reply_type     expected_replies [$];
   bus_reply_type     oldest_reply;
   bus_reply_type     next_reply;
   int                errors;
   int                checked;
   int                txdone;

   // decode one access into the operation it performs
   function automatic op_type classify_access(input logic is_write,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [DATA_W-1:0] data,
                                              input logic [SIZE_W-1:0] size);
      int first_conf1;
      int conf1_end;
      first_conf1 = CONF0_BASE + CONF1_OFFSET;
      conf1_end   = CONF0_BASE + CH_STRIDE * CHANNEL_COUNT;
      if (size != WORD_BYTES || addr[1:0] != 2'b00 || int'(addr) >= WINDOW_BYTES)
         return OP_NONE;
      if (!is_write) begin
         case (addr)
            ADDR_RAW:    return OP_RD_RAW;
            ADDR_STATUS: return OP_RD_STATUS;
            ADDR_ENABLE: return OP_RD_ENABLE;
            ADDR_CLEAR:  return OP_NONE;
            default:     return OP_RD_STORE;
         endcase
      end
      if (addr == ADDR_ENABLE)
         return OP_WR_ENABLE;
      if (addr == ADDR_CLEAR)
         return OP_WR_CLEAR;
      // conf1 word of an existing channel with the start bit set
      if (int'(addr) >= first_conf1 && int'(addr) < conf1_end &&
          ((int'(addr) - first_conf1) % CH_STRIDE) == 0 && data[0])
         return OP_WR_TXDONE;
      return OP_WR_STORE;
   endfunction

   // bring the shadow state to its reset contents
   task automatic clear_shadow();
      int idx;
      for (idx = 0; idx < STORE_WORDS; idx++)
         shadow_store[idx] = '0;
      for (idx = 0; idx < CHANNEL_COUNT; idx++) begin
         if ((CONF0_BASE + idx * CH_STRIDE) / 4 < STORE_WORDS)
            shadow_store[(CONF0_BASE + idx * CH_STRIDE) / 4] = DATA_W'(1) << CONF0_RESET_BIT;
      end
      shadow_raw    = '0;
      shadow_enable = '0;
   endtask

   // apply one access to the shadow state and work out its response word
   task automatic predict_access(input logic is_write,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] data,
                                 input logic [SIZE_W-1:0] size,
                                 output bus_reply_type reply);
      op_type op;
      int     widx;
      int     chan;
      op   = classify_access(is_write, addr, data, size);
      widx = int'(addr) / 4;
      reply.read_data = '0;
      case (op)
         OP_RD_RAW:    reply.read_data = shadow_raw;
         OP_RD_STATUS: reply.read_data = shadow_raw & shadow_enable;
         OP_RD_ENABLE: reply.read_data = shadow_enable;
         OP_RD_STORE:  reply.read_data = shadow_store[widx];
         OP_WR_ENABLE: shadow_enable = data;
         OP_WR_CLEAR:  shadow_raw = shadow_raw & ~data;
         OP_WR_STORE:  shadow_store[widx] = data;
         OP_WR_TXDONE: begin
            chan = (int'(addr) - CONF0_BASE - CONF1_OFFSET) / CH_STRIDE;
            shadow_store[widx] = {data[DATA_W-1:1], 1'b0};
            shadow_raw[(chan * TX_DONE_SPACING) % DATA_W] = 1'b1;
            txdone++;
         end
         default: ;
      endcase
      reply.irq_level = |(shadow_raw & shadow_enable);
   endtask

   // response side first, since a word never leaves in the same cycle in which it was taken
   always @(posedge clock) begin
      if (reset) begin
         clear_shadow();
         expected_replies.delete();
         errors  = 0;
         checked = 0;
         txdone  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_replies.size() == 0) begin
               $error("response word with nothing pending: read_data=%h irq_level=%b",
                      rsp_read_data, rsp_irq_level);
               errors++;
            end else begin
               oldest_reply = expected_replies.pop_front();
               if (rsp_read_data !== oldest_reply.read_data) begin
                  $error("read_data: expected %h, got %h", oldest_reply.read_data, rsp_read_data);
                  errors++;
               end
               if (rsp_irq_level !== oldest_reply.irq_level) begin
                  $error("irq_level: expected %b, got %b", oldest_reply.irq_level, rsp_irq_level);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_access(req_mode, req_address, req_write_data, req_access_size, next_reply);
            expected_replies.push_back(next_reply);
         end
      end
      mismatch_count <= errors;
      pending_words  <= expected_replies.size();
      words_checked  <= checked;
      txdone_events  <= txdone;
   end

endmodule

FILE: test/tb_top.sv
// testbench top for the register file: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
   import rcrf_pkg::*;

   localparam int WINDOW_BYTES    = 4096;
   localparam int CHANNEL_COUNT   = 8;
   localparam logic MODE_READ     = 1'b0;
   localparam logic MODE_WRITE    = 1'b1;
   localparam int MAX_IDLE        = 12;
   localparam int LONG_HOLD       = 80;
   localparam int RANDOM_ACCESSES = 450;
   localparam int PHASES          = 6;
   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 300000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_mode;
   logic [ADDR_W-1:0]   req_address;
   logic [DATA_W-1:0]   req_write_data;
   logic [SIZE_W-1:0]   req_access_size;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                rsp_irq_level;

   int                  mismatch_count;
   int                  pending_words;
   int                  words_checked;
   int                  txdone_events;
   int                  cycle_count;
   int                  phase;

   // idling controls shared with the response side
   bit                  tx_quiet;
   bit                  rx_quiet;
   bit                  long_hold_wanted;

   remote_ctrl_register_file_irq #(
      .WINDOW_BYTES  (WINDOW_BYTES),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_access_size (req_access_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_level   (rsp_irq_level)
   );

   rcrf_checker #(
      .WINDOW_BYTES  (WINDOW_BYTES),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_access_size (req_access_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_level   (rsp_irq_level),
      .mismatch_count  (mismatch_count),
      .pending_words   (pending_words),
      .words_checked   (words_checked),
      .txdone_events   (txdone_events)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still pending", cycle_count, pending_words);
      $display("DONE: errors detected");
      $finish;
   end

   // response side: random stalls, quiet stretches and one long hold-off
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (long_hold_wanted) begin
            stall = LONG_HOLD;
            long_hold_wanted = 1'b0;
         end else if (rx_quiet) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, MAX_IDLE);
         end
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // offer one bus word and hold it until taken
   task automatic send_access(input logic mode, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data, input logic [SIZE_W-1:0] size);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_address     <= addr;
      req_write_data  <= data;
      req_access_size <= size;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // stop offering and wait for every pending response
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   // random access, weighted toward interrupt and channel registers
   task automatic send_random_access();
      logic                mode;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   data;
      logic [SIZE_W-1:0]   size;
      int                  pick;
      int                  chan;
      mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
      pick = $urandom_range(0, 99);
      chan = $urandom_range(0, CHANNEL_COUNT + 1);
      if (pick < 25) begin
         case ($urandom_range(0, 3))
            0:       addr = ADDR_RAW;
            1:       addr = ADDR_STATUS;
            2:       addr = ADDR_ENABLE;
            default: addr = ADDR_CLEAR;
         endcase
      end else if (pick < 60) begin
         addr = ADDR_W'(CONF0_BASE + chan * CH_STRIDE +
                        ($urandom_range(0, 1) ? CONF1_OFFSET : 0));
      end else if (pick < 85) begin
         addr = ADDR_W'($urandom_range(0, WINDOW_BYTES / 4 - 1) * 4);
      end else begin
         addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
      end
      size = ($urandom_range(0, 9) < 8) ? WORD_BYTES : SIZE_W'($urandom_range(1, 8));
      case ($urandom_range(0, 7))
         0:       data = '0;
         1:       data = '1;
         2:       data = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
         default: data = $urandom;
      endcase
      send_access(mode, addr, data, size);
   endtask

   // stimulus
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_READ;
      req_address      = '0;
      req_write_data   = '0;
      req_access_size  = WORD_BYTES;
      tx_quiet         = 1'b0;
      rx_quiet         = 1'b0;
      long_hold_wanted = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset values, interrupt registers, transmit done, ignored accesses
      send_access(MODE_READ,  ADDR_W'(CONF0_BASE), '0, WORD_BYTES);
      send_access(MODE_READ,  ADDR_W'(CONF0_BASE + 7 * CH_STRIDE), '0, WORD_BYTES);
      send_access(MODE_READ,  ADDR_W'(CONF0_BASE + 8 * CH_STRIDE), '0, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_ENABLE, '1, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_W'(CONF0_BASE + CONF1_OFFSET), '1, WORD_BYTES);
      send_access(MODE_READ,  ADDR_W'(CONF0_BASE + CONF1_OFFSET), '0, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_W'(CONF0_BASE + 7 * CH_STRIDE + CONF1_OFFSET),
                  32'h0000_0001, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_W'(CONF0_BASE + 3 * CH_STRIDE + CONF1_OFFSET),
                  32'hAAAA_AAAA, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_W'(CONF0_BASE + 8 * CH_STRIDE + CONF1_OFFSET),
                  32'h0000_0001, WORD_BYTES);
      send_access(MODE_READ,  ADDR_W'(CONF0_BASE + 8 * CH_STRIDE + CONF1_OFFSET), '0, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_RAW, 32'h1234_5678, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_STATUS, '1, WORD_BYTES);
      send_access(MODE_READ,  ADDR_RAW, '0, WORD_BYTES);
      send_access(MODE_READ,  ADDR_STATUS, '0, WORD_BYTES);
      send_access(MODE_READ,  ADDR_CLEAR, '0, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_CLEAR, 32'h0000_0001, WORD_BYTES);
      send_access(MODE_READ,  ADDR_RAW, '0, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_ENABLE, '0, WORD_BYTES);
      send_access(MODE_READ,  ADDR_ENABLE, '0, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_CLEAR, '1, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_W'(CONF0_BASE + 2), '1, WORD_BYTES);
      send_access(MODE_WRITE, ADDR_W'(0), '1, SIZE_W'(8));
      send_access(MODE_READ,  ADDR_W'(CONF0_BASE), '0, SIZE_W'(1));
      send_access(MODE_WRITE, ADDR_W'(WINDOW_BYTES - 4), '1, WORD_BYTES);
      send_access(MODE_READ,  ADDR_W'(WINDOW_BYTES - 4), '0, WORD_BYTES);
      send_access(MODE_READ,  ADDR_W'(0), '0, WORD_BYTES);
      wait_drained();

      // random phases with different idling on each side
      for (phase = 0; phase < PHASES; phase++) begin
         tx_quiet = (phase == 1 || phase == 2 || phase == 3);
         rx_quiet = (phase == 1 || phase == 4);
         if (phase == 3)
            long_hold_wanted = 1'b1;
         repeat (RANDOM_ACCESSES / PHASES) send_random_access();
         if (phase == 2 || phase == 4)
            wait_drained();
      end

      // let the last responses come out
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d response words, %0d transmit-done interrupts raised",
               words_checked, txdone_events);
      $display("phases covered full rate, random gaps on both sides and a long response stall");
      if (mismatch_count == 0 && pending_words == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: remote_ctrl_register_file_irq.f
sv/rcrf_pkg.sv
sv/rcrf_front.sv
sv/rcrf_queue.sv
sv/rcrf_back.sv
sv/remote_ctrl_register_file_irq.sv
test/rcrf_checker.sv
test/tb_top.sv
